>>> src/assert_macros.svh
// Assertion helpers used by the stack engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define SE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define SE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> src/se_pkg.sv
package se_pkg;
	localparam int DEPTH = 64;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int LIMIT = 64;

	localparam logic [2:0] OPC_PUSH   = 3'd0;
	localparam logic [2:0] OPC_POP    = 3'd1;
	localparam logic [2:0] OPC_MIDDLE = 3'd2;
	localparam logic [2:0] OPC_MINMAX = 3'd3;
	localparam logic [2:0] OPC_SORT   = 3'd4;
	localparam logic [2:0] OPC_DUMP   = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [2:0]         opcode;
		logic signed [31:0] push_value;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic signed [31:0] second_value;
		logic [1:0]         status;
		logic [6:0]         fill_count;
		logic               last;
	} rsp_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_PUSH,
		CELL_POP,
		CELL_ROT,
		CELL_SORT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     is_end;
		logic     pair_lo;
		logic     pair_hi;
	} cell_ctl_t;
endpackage

>>> src/se_cell.sv
module se_cell (
	input  logic                     clk,
	input  se_pkg::cell_ctl_t        ctl,
	input  logic signed [31:0]       up,
	input  logic signed [31:0]       dn,
	input  logic signed [31:0]       top,
	output logic signed [31:0]       q
);
	import se_pkg::*;

	logic signed [31:0] q_q;

	assign q = q_q;

	// Shift, rotate or compare-swap with a neighbor
	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_PUSH: q_q <= up;
			CELL_POP:  q_q <= dn;
			CELL_ROT:  q_q <= ctl.is_end ? top : dn;
			CELL_SORT: begin
				if (ctl.pair_lo) begin
					q_q <= (dn < q_q) ? dn : q_q;
				end else if (ctl.pair_hi) begin
					q_q <= (up > q_q) ? up : q_q;
				end
			end
			default: q_q <= q_q;
		endcase
	end
endmodule

>>> src/stack_engine_with_sort_minmax.sv
// Stack engine: a chain of DEPTH cells, cell 0 is the top of the stack.
// Command channel (cmd_valid/cmd_stall/cmd) carries an opcode and a push
// value; response channel (rsp_valid/rsp_stall/rsp) carries the results.
// Push and pop may follow each other every cycle while the response is
// not stalled; the response appears in the cycle after acceptance.
// Middle, min/max and dump rotate the chain once, one step per entry,
// reading cell 0 at each step; dump sends one response per entry, top first.
// Sort runs count passes of odd-even compare-swap across the cells, then
// sends one response. A query on an empty stack answers with status empty.
// While a scan or sort runs, cmd_stall is high. A stalled response holds
// the engine at the step that needs to send; the output register lets a
// new command be taken while the previous response waits unless stalled.
// Reset empties the stack; cell contents are not cleared.
module stack_engine_with_sort_minmax (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cmd_valid,
	output logic         cmd_stall,
	input  se_pkg::cmd_t cmd,
	output logic         rsp_valid,
	input  logic         rsp_stall,
	output se_pkg::rsp_t rsp
);
	import se_pkg::*;
	`include "assert_macros.svh"

	typedef enum logic [1:0] {S_IDLE, S_ROT, S_SORT} state_t;

	state_t             state_q;
	logic [2:0]         op_q;
	logic [CW-1:0]      step_q;
	logic [CW-1:0]      count_q;
	logic signed [31:0] lo_q, hi_q, mid_q;
	logic               rsp_v_q;
	rsp_t               rsp_q;

	logic signed [31:0] cq [DEPTH];
	cell_op_t           cop;
	logic               out_free, accept, emit_now, adv;
	logic [CW-1:0]      lastix, midk;
	logic signed [31:0] c0, nlo, nhi;
	logic               rsp_set;
	rsp_t               rsp_d;

	assign out_free  = !rsp_v_q || !rsp_stall;
	assign cmd_stall = !(state_q == S_IDLE && out_free);
	assign accept    = cmd_valid && !cmd_stall;
	assign rsp_valid = rsp_v_q;
	assign rsp       = rsp_q;
	assign c0        = cq[0];
	assign lastix    = count_q - CW'(1);
	assign midk      = lastix - (lastix >> 1);
	assign nlo       = (step_q == '0) ? c0 : ((c0 < lo_q) ? c0 : lo_q);
	assign nhi       = (step_q == '0) ? c0 : ((c0 > hi_q) ? c0 : hi_q);

	// Decide whether this step sends a response and may advance
	always_comb begin
		emit_now = 1'b0;
		if (state_q == S_ROT && op_q == OPC_DUMP) begin
			emit_now = int'(step_q) < LIMIT;
		end else if (state_q != S_IDLE) begin
			emit_now = step_q == lastix;
		end
		adv = !emit_now || out_free;
	end

	// Pick the chain operation for this cycle
	always_comb begin
		cop = CELL_HOLD;
		unique case (state_q)
			S_IDLE: begin
				if (accept && cmd.opcode == OPC_PUSH && int'(count_q) < DEPTH) begin
					cop = CELL_PUSH;
				end else if (accept && cmd.opcode == OPC_POP && count_q != '0) begin
					cop = CELL_POP;
				end
			end
			S_ROT:   cop = adv ? CELL_ROT : CELL_HOLD;
			S_SORT:  cop = adv ? CELL_SORT : CELL_HOLD;
			default: cop = CELL_HOLD;
		endcase
	end

	// Build the chain of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_ctl_t          ctl;
		logic signed [31:0] up, dn;

		assign ctl = '{
			op:      cop,
			is_end:  CW'(i) == lastix,
			pair_lo: ((i % 2) == int'(step_q[0])) && (int'(count_q) > i + 1),
			pair_hi: (i >= 1) && (((i - 1) % 2) == int'(step_q[0]))
				&& (int'(count_q) > i)
		};
		if (i == 0) begin : g_top
			assign up = cmd.push_value;
		end else begin : g_mid
			assign up = cq[i-1];
		end
		if (i == DEPTH - 1) begin : g_bot
			assign dn = '0;
		end else begin : g_in
			assign dn = cq[i+1];
		end

		se_cell u_cell (
			.clk (clk),
			.ctl (ctl),
			.up  (up),
			.dn  (dn),
			.top (c0),
			.q   (cq[i])
		);
	end

	// Form the next response transaction
	always_comb begin
		rsp_set = 1'b0;
		rsp_d   = '{value: '0, second_value: '0, status: ST_OK,
			fill_count: count_q[6:0], last: 1'b1};
		if (state_q == S_IDLE) begin
			if (accept && cmd.opcode == OPC_PUSH) begin
				rsp_set = 1'b1;
				if (int'(count_q) < DEPTH) begin
					rsp_d.fill_count = 7'(count_q + CW'(1));
				end else begin
					rsp_d.status = ST_FULL;
				end
			end else if (accept && cmd.opcode <= OPC_DUMP) begin
				if (count_q == '0) begin
					rsp_set      = 1'b1;
					rsp_d.status = ST_EMPTY;
				end else if (cmd.opcode == OPC_POP) begin
					rsp_set          = 1'b1;
					rsp_d.value      = c0;
					rsp_d.fill_count = 7'(lastix);
				end
			end
		end else if (adv && emit_now) begin
			rsp_set = 1'b1;
			if (state_q == S_ROT) begin
				case (op_q)
					OPC_DUMP: begin
						rsp_d.value = c0;
						rsp_d.last  = (step_q == lastix) || (int'(step_q) + 1 == LIMIT);
					end
					OPC_MINMAX: begin
						rsp_d.value        = nlo;
						rsp_d.second_value = nhi;
					end
					default: rsp_d.value = (step_q == midk) ? c0 : mid_q;
				endcase
			end
		end
	end

	// Hold control state and the response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			step_q  <= '0;
			op_q    <= OPC_PUSH;
			rsp_v_q <= 1'b0;
			rsp_q   <= '0;
		end else begin
			rsp_v_q <= rsp_set || (rsp_v_q && !out_free);
			if (rsp_set) begin
				rsp_q <= rsp_d;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q   <= cmd.opcode;
						step_q <= '0;
						if (cmd.opcode == OPC_PUSH) begin
							if (int'(count_q) < DEPTH) begin
								count_q <= count_q + CW'(1);
							end
						end else if (cmd.opcode <= OPC_DUMP && count_q != '0) begin
							if (cmd.opcode == OPC_POP) begin
								count_q <= lastix;
							end else if (cmd.opcode == OPC_SORT) begin
								state_q <= S_SORT;
							end else begin
								state_q <= S_ROT;
							end
						end
					end
				end
				S_ROT, S_SORT: begin
					if (adv) begin
						lo_q   <= nlo;
						hi_q   <= nhi;
						step_q <= step_q + CW'(1);
						if (step_q == midk) begin
							mid_q <= c0;
						end
						if (step_q == lastix) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`SE_ASSERT_IMP(a_count_max, clk, arst_n, 1'b1, int'(count_q) <= DEPTH)
	`SE_ASSERT_IMP(a_busy_nonempty, clk, arst_n, state_q != S_IDLE, count_q != '0)
	`SE_ASSERT_NEXT(a_push_grows, clk, arst_n,
		accept && cmd.opcode == OPC_PUSH && int'(count_q) < DEPTH,
		count_q == $past(count_q) + CW'(1))
	`SE_ASSERT_NEXT(a_done_sends, clk, arst_n,
		state_q != S_IDLE && adv && step_q == lastix, rsp_v_q)
endmodule

>>> tb/tb_stack_engine_with_sort_minmax.sv
module tb_stack_engine_with_sort_minmax;
	import se_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;

	localparam logic [2:0] OPC_SPARE_A = 3'd6;
	localparam logic [2:0] OPC_SPARE_B = 3'd7;

	// stack mirror and queue of pending responses
	class stack_scoreboard;
		logic signed [31:0] words[$];
		rsp_t               pending[$];
		int                 mismatches;

		function void push_rsp(logic signed [31:0] v, logic signed [31:0] v2,
			logic [1:0] st, logic fin);
			rsp_t r;
			r.value        = v;
			r.second_value = v2;
			r.status       = st;
			r.fill_count   = 7'(words.size());
			r.last         = fin;
			pending.push_back(r);
		endfunction

		// note an accepted command and predict its responses
		function void note_command(cmd_t c);
			logic signed [31:0] lo, hi, key;
			int n, j;
			if (c.opcode > OPC_DUMP)
				return;
			if (c.opcode == OPC_PUSH) begin
				if (words.size() >= DEPTH) begin
					push_rsp(0, 0, ST_FULL, 1'b1);
				end else begin
					words.push_back(c.push_value);
					push_rsp(0, 0, ST_OK, 1'b1);
				end
				return;
			end
			if (words.size() == 0) begin
				push_rsp(0, 0, ST_EMPTY, 1'b1);
				return;
			end
			case (c.opcode)
				OPC_POP: begin
					key = words.pop_back();
					push_rsp(key, 0, ST_OK, 1'b1);
				end
				OPC_MIDDLE: begin
					push_rsp(words[(words.size() - 1) / 2], 0, ST_OK, 1'b1);
				end
				OPC_MINMAX: begin
					lo = words[0];
					hi = words[0];
					foreach (words[i]) begin
						if (words[i] < lo) lo = words[i];
						if (words[i] > hi) hi = words[i];
					end
					push_rsp(lo, hi, ST_OK, 1'b1);
				end
				OPC_SORT: begin
					// largest at the bottom, smallest on top
					for (int i = 1; i < words.size(); i++) begin
						key = words[i];
						j = i;
						while (j > 0 && words[j - 1] < key) begin
							words[j] = words[j - 1];
							j--;
						end
						words[j] = key;
					end
					push_rsp(0, 0, ST_OK, 1'b1);
				end
				default: begin
					n = words.size() < LIMIT ? words.size() : LIMIT;
					for (int i = 0; i < n; i++)
						push_rsp(words[words.size() - 1 - i], 0, ST_OK, i + 1 == n);
				end
			endcase
		endfunction

		// compare one response with the oldest prediction
		function void check_response(rsp_t got);
			rsp_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response %p", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %p actual %p", want, got);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	stack_scoreboard sb;
	int  cycles;
	bit  quiet_phase;
	bit  hold_rsp;

	stack_engine_with_sort_minmax i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// count cycles and stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("stack_engine_with_sort_minmax verification failed");
			$finish;
		end
	end

	// sample transactions at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && !cmd_stall)
				sb.note_command(cmd);
			if (rsp_valid && !rsp_stall)
				sb.check_response(rsp);
		end
	end

	// send one command, sometimes idling for a random burst first
	task automatic send_cmd(logic [2:0] op, logic signed [31:0] v);
		if (!quiet_phase && $urandom_range(0, 5) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		cmd.opcode     <= op;
		cmd.push_value <= v;
		cmd_valid      <= 1'b1;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(0, 4))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $signed($urandom_range(0, 20)) - 10;
			default: return $urandom;
		endcase
	endfunction

	// drop valid and wait until every predicted response has come
	task automatic wait_drained();
		cmd_valid <= 1'b0;
		do @(negedge clk); while (sb.pending.size() != 0);
	endtask

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_rsp) begin
				rsp_stall <= 1'b1;
				repeat (300) @(negedge clk);
				hold_rsp = 1'b0;
				rsp_stall <= 1'b0;
			end else if (!quiet_phase && $urandom_range(0, 6) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 15)) @(negedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	initial begin
		logic [2:0] op;
		int r;
		sb          = new();
		cycles      = 0;
		quiet_phase = 1'b0;
		hold_rsp    = 1'b0;
		cmd_valid   = 1'b0;
		cmd         = '0;
		arst_n      = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty queries, extremes, unused opcodes, sort and dump
		for (int k = OPC_POP; k <= OPC_DUMP; k++) send_cmd(k[2:0], 0);
		send_cmd(OPC_PUSH, 32'sh7fffffff);
		send_cmd(OPC_PUSH, 32'sh80000000);
		send_cmd(OPC_PUSH, -1);
		send_cmd(OPC_PUSH, 0);
		send_cmd(OPC_SPARE_A, 5);
		send_cmd(OPC_SPARE_B, 5);
		send_cmd(OPC_MIDDLE, 0);
		send_cmd(OPC_MINMAX, 0);
		send_cmd(OPC_DUMP, 0);
		send_cmd(OPC_SORT, 0);
		send_cmd(OPC_DUMP, 0);
		send_cmd(OPC_POP, 0);
		send_cmd(OPC_POP, 0);

		// fill to full while the receiver holds off, then push once more
		hold_rsp = 1'b1;
		for (int k = 0; k < DEPTH + 1; k++) send_cmd(OPC_PUSH, rand_word());
		wait_drained();
		while (hold_rsp) @(negedge clk);
		send_cmd(OPC_SORT, 0);
		send_cmd(OPC_MINMAX, 0);
		send_cmd(OPC_MIDDLE, 0);
		send_cmd(OPC_DUMP, 0);

		// random mix, pushes and pops dominant
		for (int k = 0; k < 160; k++) begin
			if (k == 80) wait_drained();
			if (k == 120) quiet_phase = 1'b1;
			r = $urandom_range(0, 99);
			if (r < 45) op = OPC_PUSH;
			else if (r < 75) op = OPC_POP;
			else if (r < 82) op = OPC_MIDDLE;
			else if (r < 89) op = OPC_MINMAX;
			else if (r < 93) op = OPC_SORT;
			else if (r < 97) op = OPC_DUMP;
			else op = ($urandom_range(0, 1) != 0) ? OPC_SPARE_B : OPC_SPARE_A;
			send_cmd(op, rand_word());
		end
		// drain the stack
		for (int k = 0; k < DEPTH + 1; k++) send_cmd(OPC_POP, 0);

		wait_drained();
		repeat (200) @(negedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("stack_engine_with_sort_minmax verification clean");
		else
			$display("stack_engine_with_sort_minmax verification failed");
		$finish;
	end
endmodule
